/* rtl/pid_ma_pkg.sv */
// Shared constants, codes and types for the PID controller with moving average.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package pid_ma_pkg;

    // Window and sample geometry
    localparam int WINDOW      = 5;
    localparam int SAMPLE_BITS = 12;
    localparam int HIST        = WINDOW - 1;          // taps kept besides the new sample
    localparam int ACC_W       = SAMPLE_BITS + $clog2(WINDOW);

    // Divide by WINDOW: multiply by ceil(2^DIV_SHIFT / WINDOW), keep the upper bits.
    // Exact for every window sum below 2^ACC_W.
    localparam int DIV_SHIFT   = ACC_W + $clog2(WINDOW);
    localparam int DIV_MULT    = ((2 ** DIV_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int MULT_W      = DIV_SHIFT + 1;

    // Control law widths
    localparam int SETPOINT_W  = 8;
    localparam int GAIN_W      = 24;
    localparam int FRAC_BITS   = 12;
    localparam int ERR_W       = SAMPLE_BITS + 1;
    localparam int DIFF_W      = ERR_W + 1;
    localparam int SUM_W       = 32;
    localparam int P_W         = GAIN_W + ERR_W;
    localparam int D_W         = GAIN_W + DIFF_W;
    localparam int I_W         = GAIN_W + SUM_W;
    localparam int TOT_W       = I_W + 2;
    localparam int DRIVE_W     = 7;
    localparam int DRIVE_MAX   = 100;

    // Ports
    localparam int MODE_W      = 2;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 32;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = GAIN_W;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ARM   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STEP  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DERIV_GAIN = 2'd3;

    // One control step handed from the front end to the control law
    typedef struct packed {
        logic                          ctrl;      // run the control law
        logic                          updated;   // drive_updated of the result
        logic [SAMPLE_BITS-1:0]        avg;
        logic signed [ERR_W-1:0]       err;
        logic signed [ERR_W-1:0]       err_prev;
        logic signed [SUM_W-1:0]       err_sum;
    } step_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
    } gains_t;

endpackage

/* rtl/pid_ma_front.sv */
// Front end: input register, sample delay line, window average, error and error sum.
// Depends on pid_ma_pkg.
`timescale 1ns / 1ps

module pid_ma_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pid_ma_pkg::MODE_W-1:0]        s_mode,
    input  logic [pid_ma_pkg::SAMPLE_BITS-1:0]   s_sample,
    input  logic [pid_ma_pkg::SETPOINT_W-1:0]    setpoint,
    output logic                                 step_valid,
    input  logic                                 step_ready,
    output pid_ma_pkg::step_t                    step
);

    // Input stage
    logic                                 s1_valid_reg;
    logic [pid_ma_pkg::MODE_W-1:0]        s1_mode_reg;
    logic [pid_ma_pkg::SAMPLE_BITS-1:0]   s1_sample_reg;
    logic                                 s1_ready;
    logic                                 s1_adv;

    // Loop state
    logic [pid_ma_pkg::SAMPLE_BITS-1:0]   win_reg [pid_ma_pkg::HIST];
    logic [pid_ma_pkg::SAMPLE_BITS-1:0]   win_next [pid_ma_pkg::HIST];
    logic                                 armed_reg, armed_next;
    logic signed [pid_ma_pkg::ERR_W-1:0]  err_reg, err_next;
    logic signed [pid_ma_pkg::ERR_W-1:0]  err_prev_reg, err_prev_next;
    logic signed [pid_ma_pkg::SUM_W-1:0]  sum_reg, sum_next;

    // Step stage
    logic                                 s2_valid_reg;
    logic                                 s2_ready;
    pid_ma_pkg::step_t                    step_reg, step_next;

    // Datapath
    logic [pid_ma_pkg::ACC_W-1:0]                     acc;
    logic [pid_ma_pkg::ACC_W+pid_ma_pkg::MULT_W-1:0]  quot_prod;
    logic [pid_ma_pkg::SAMPLE_BITS-1:0]               avg;
    logic signed [pid_ma_pkg::ERR_W-1:0]              err_new;
    logic signed [pid_ma_pkg::SUM_W:0]                sum_wide;
    logic signed [pid_ma_pkg::SUM_W-1:0]              sum_sat;

    assign s2_ready   = !s2_valid_reg || step_ready;
    assign s1_adv     = s1_valid_reg && s2_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign s_tready   = s1_ready;
    assign step_valid = s2_valid_reg;
    assign step       = step_reg;

    // Sum the window as it stands after the shift, then divide by the window length
    always_comb begin
        acc = pid_ma_pkg::ACC_W'(s1_sample_reg);
        for (int i = 0; i < pid_ma_pkg::HIST; i++) begin
            acc = acc + pid_ma_pkg::ACC_W'(win_reg[i]);
        end
        quot_prod = (pid_ma_pkg::ACC_W + pid_ma_pkg::MULT_W)'(acc)
                  * (pid_ma_pkg::ACC_W + pid_ma_pkg::MULT_W)'(pid_ma_pkg::DIV_MULT);
        avg       = quot_prod[pid_ma_pkg::DIV_SHIFT +: pid_ma_pkg::SAMPLE_BITS];
        err_new   = $signed(pid_ma_pkg::ERR_W'(avg) - pid_ma_pkg::ERR_W'(setpoint));
    end

    // Accumulate the previous error, saturating at the signed 32-bit limits
    always_comb begin
        sum_wide = (pid_ma_pkg::SUM_W + 1)'(sum_reg) + (pid_ma_pkg::SUM_W + 1)'(err_reg);
        if (sum_wide[pid_ma_pkg::SUM_W] != sum_wide[pid_ma_pkg::SUM_W-1]) begin
            sum_sat = sum_wide[pid_ma_pkg::SUM_W] ?
                      {1'b1, {(pid_ma_pkg::SUM_W-1){1'b0}}} :
                      {1'b0, {(pid_ma_pkg::SUM_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[pid_ma_pkg::SUM_W-1:0];
        end
    end

    // Decode the mode and form the next loop state and step
    always_comb begin
        win_next      = win_reg;
        armed_next    = armed_reg;
        err_next      = err_reg;
        err_prev_next = err_prev_reg;
        sum_next      = sum_reg;
        step_next     = '0;
        unique case (s1_mode_reg)
            pid_ma_pkg::MODE_CLEAR: begin
                armed_next        = 1'b0;
                err_next          = '0;
                err_prev_next     = '0;
                sum_next          = '0;
                step_next.updated = 1'b1;
            end
            pid_ma_pkg::MODE_ARM: begin
                armed_next = 1'b1;
            end
            pid_ma_pkg::MODE_STEP: begin
                if (armed_reg) begin
                    for (int i = pid_ma_pkg::HIST - 1; i > 0; i--) begin
                        win_next[i] = win_reg[i-1];
                    end
                    win_next[0]        = s1_sample_reg;
                    err_prev_next      = err_reg;
                    err_next           = err_new;
                    sum_next           = sum_sat;
                    step_next.ctrl     = 1'b1;
                    step_next.updated  = 1'b1;
                    step_next.avg      = avg;
                    step_next.err      = err_new;
                    step_next.err_prev = err_reg;
                    step_next.err_sum  = sum_sat;
                end
            end
            default: begin
                // unused mode: no state change, all-zero result
            end
        endcase
    end

    // Advance the input stage, loop state and step stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            armed_reg    <= 1'b0;
            err_reg      <= '0;
            err_prev_reg <= '0;
            sum_reg      <= '0;
            for (int i = 0; i < pid_ma_pkg::HIST; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_ready && s_tvalid) begin
                s1_mode_reg   <= s_mode;
                s1_sample_reg <= s_sample;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s1_adv) begin
                win_reg      <= win_next;
                armed_reg    <= armed_next;
                err_reg      <= err_next;
                err_prev_reg <= err_prev_next;
                sum_reg      <= sum_next;
                step_reg     <= step_next;
            end
        end
    end

endmodule

/* rtl/pid_ma_law.sv */
// Control law: gain products, then sum, scale and clamp into the result register.
// Depends on pid_ma_pkg.
`timescale 1ns / 1ps

module pid_ma_law (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  pid_ma_pkg::gains_t                   gains,
    input  logic                                 step_valid,
    output logic                                 step_ready,
    input  pid_ma_pkg::step_t                    step,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pid_ma_pkg::DRIVE_W-1:0]       m_drive,
    output logic                                 m_updated,
    output logic [pid_ma_pkg::SAMPLE_BITS-1:0]   m_avg,
    output logic [pid_ma_pkg::ERR_W-1:0]         m_err
);

    // Product stage
    logic                                 pa_valid_reg;
    logic                                 pa_ready;
    logic                                 pa_adv;
    logic                                 pa_ctrl_reg;
    logic                                 pa_updated_reg;
    logic [pid_ma_pkg::SAMPLE_BITS-1:0]   pa_avg_reg;
    logic signed [pid_ma_pkg::ERR_W-1:0]  pa_err_reg;
    logic signed [pid_ma_pkg::P_W-1:0]    pa_p_reg, pa_p_next;
    logic signed [pid_ma_pkg::I_W-1:0]    pa_i_reg, pa_i_next;
    logic signed [pid_ma_pkg::D_W-1:0]    pa_d_reg, pa_d_next;
    logic signed [pid_ma_pkg::DIFF_W-1:0] diff;

    // Result stage
    logic                                 out_valid_reg;
    logic                                 out_ready;
    logic [pid_ma_pkg::DRIVE_W-1:0]       drive_reg, drive_next;
    logic                                 updated_reg;
    logic [pid_ma_pkg::SAMPLE_BITS-1:0]   avg_reg;
    logic [pid_ma_pkg::ERR_W-1:0]         err_out_reg;
    logic signed [pid_ma_pkg::TOT_W-1:0]  total;
    logic [pid_ma_pkg::TOT_W-pid_ma_pkg::FRAC_BITS-1:0] whole;

    assign out_ready  = !out_valid_reg || m_tready;
    assign pa_adv     = pa_valid_reg && out_ready;
    assign pa_ready   = !pa_valid_reg || out_ready;
    assign step_ready = pa_ready;

    assign m_tvalid   = out_valid_reg;
    assign m_drive    = drive_reg;
    assign m_updated  = updated_reg;
    assign m_avg      = avg_reg;
    assign m_err      = err_out_reg;

    // Gain products, one multiplier each
    always_comb begin
        diff      = pid_ma_pkg::DIFF_W'(step.err) - pid_ma_pkg::DIFF_W'(step.err_prev);
        pa_p_next = gains.kp * step.err;
        pa_i_next = gains.ki * step.err_sum;
        pa_d_next = gains.kd * diff;
    end

    // Sum the terms; a negative total truncates to at most zero, so it clamps to zero
    always_comb begin
        total = pid_ma_pkg::TOT_W'(pa_p_reg) + pid_ma_pkg::TOT_W'(pa_i_reg)
              + pid_ma_pkg::TOT_W'(pa_d_reg);
        whole = total[pid_ma_pkg::TOT_W-1:pid_ma_pkg::FRAC_BITS];
        if (!pa_ctrl_reg || total[pid_ma_pkg::TOT_W-1]) begin
            drive_next = '0;
        end else if (whole > (pid_ma_pkg::TOT_W - pid_ma_pkg::FRAC_BITS)'(pid_ma_pkg::DRIVE_MAX))
        begin
            drive_next = pid_ma_pkg::DRIVE_W'(pid_ma_pkg::DRIVE_MAX);
        end else begin
            drive_next = whole[pid_ma_pkg::DRIVE_W-1:0];
        end
    end

    // Advance the product and result stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pa_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pa_ready) begin
                pa_valid_reg <= step_valid;
            end
            if (pa_ready && step_valid) begin
                pa_ctrl_reg    <= step.ctrl;
                pa_updated_reg <= step.updated;
                pa_avg_reg     <= step.avg;
                pa_err_reg     <= step.err;
                pa_p_reg       <= pa_p_next;
                pa_i_reg       <= pa_i_next;
                pa_d_reg       <= pa_d_next;
            end
            if (out_ready) begin
                out_valid_reg <= pa_valid_reg;
            end
            if (pa_adv) begin
                drive_reg   <= drive_next;
                updated_reg <= pa_updated_reg;
                avg_reg     <= pa_avg_reg;
                err_out_reg <= pa_err_reg;
            end
        end
    end

endmodule

/* rtl/pid_with_moving_average.sv */
// PID controller with five-sample moving average and 0..100 drive clamp (top level).
// Depends on pid_ma_pkg, pid_ma_front and pid_ma_law.
// Path from input accept to m_tvalid: input, step, product and result registers; the loop
// state updates as each item advances. Throughput: one item per cycle unless m_tready stalls.
// Reset (aresetn low, synchronous) clears window, errors, sum, armed, gains and setpoint.
`timescale 1ns / 1ps

module pid_with_moving_average (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input items
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [pid_ma_pkg::S_TDATA_W-1:0]      s_tdata,   // [11:0] sample, rest zero
    input  logic [pid_ma_pkg::MODE_W-1:0]         s_tuser,   // [1:0] mode
    // result items
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [pid_ma_pkg::M_TDATA_W-1:0]      m_tdata,   // [6:0] drive, [18:7] average,
                                                             // [31:19] error_out
    output logic                                  m_tuser,   // [0] drive_updated
    // configuration writes
    input  logic                                  cfg_wr_en,
    input  logic [pid_ma_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pid_ma_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [pid_ma_pkg::SETPOINT_W-1:0]    setpoint_reg;
    pid_ma_pkg::gains_t                   gains_reg;

    logic                                 step_valid;
    logic                                 step_ready;
    pid_ma_pkg::step_t                    step;

    logic [pid_ma_pkg::DRIVE_W-1:0]       drive;
    logic [pid_ma_pkg::SAMPLE_BITS-1:0]   average;
    logic [pid_ma_pkg::ERR_W-1:0]         error_out;

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg <= '0;
            gains_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                pid_ma_pkg::REG_SETPOINT:   setpoint_reg <= cfg_wdata[pid_ma_pkg::SETPOINT_W-1:0];
                pid_ma_pkg::REG_PROP_GAIN:  gains_reg.kp <= cfg_wdata;
                pid_ma_pkg::REG_INTEG_GAIN: gains_reg.ki <= cfg_wdata;
                pid_ma_pkg::REG_DERIV_GAIN: gains_reg.kd <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    pid_ma_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_mode     (s_tuser),
        .s_sample   (s_tdata[pid_ma_pkg::SAMPLE_BITS-1:0]),
        .setpoint   (setpoint_reg),
        .step_valid (step_valid),
        .step_ready (step_ready),
        .step       (step)
    );

    pid_ma_law u_law (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .gains      (gains_reg),
        .step_valid (step_valid),
        .step_ready (step_ready),
        .step       (step),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_drive    (drive),
        .m_updated  (m_tuser),
        .m_avg      (average),
        .m_err      (error_out)
    );

    // Pack the result fields, drive in the lowest bits
    assign m_tdata = {error_out, average, drive};

endmodule

/* rtl/pid_ma_checker.sv */
// Port-level checks for pid_with_moving_average, attached by bind.
// Depends on pid_ma_pkg and the top level's ports.
`timescale 1ns / 1ps

module pid_ma_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [pid_ma_pkg::M_TDATA_W-1:0]      m_tdata,
    input logic                                  m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or dropped");

    // Drive never leaves the clamp range
    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            m_tdata[pid_ma_pkg::DRIVE_W-1:0] <= pid_ma_pkg::DRIVE_W'(pid_ma_pkg::DRIVE_MAX))
        else $error("drive above clamp");

    // A result without a new drive value carries all-zero data
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("non-updating result carries data");

    // Input stalls only when the pipeline is backed up to a waiting result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind pid_with_moving_average pid_ma_checker u_pid_ma_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* tb/tb_pid_with_moving_average.sv */
// Self-checking testbench for pid_with_moving_average: streams mode/sample items,
// predicts each result in a scoreboard class and compares it field by field.
// Depends on pid_ma_pkg and the pid_with_moving_average top level.
`timescale 1ns / 1ps

module tb_pid_with_moving_average;
    import pid_ma_pkg::*;

    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 100000;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 8;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 230;
    localparam int SUM_LIMIT   = 32'h7FFF_FFFF;

    // One expected result item
    typedef struct packed {
        logic [DRIVE_W-1:0]     drive;
        logic                   updated;
        logic [SAMPLE_BITS-1:0] average;
        logic [ERR_W-1:0]       error_out;
    } drive_result_t;

    // Loop predictor and queue of expected drive results
    class pid_scoreboard;
        int unsigned   window [WINDOW];
        bit            armed;
        int            error_now;
        int            error_prev;
        int            error_sum;
        int unsigned   setpoint;
        int            kp;
        int            ki;
        int            kd;
        int            fails;
        drive_result_t pending_results [$];

        function new();
            int i;
            for (i = 0; i < WINDOW; i++) window[i] = 0;
            armed = 0;
            error_now = 0;
            error_prev = 0;
            error_sum = 0;
            setpoint = 0;
            kp = 0;
            ki = 0;
            kd = 0;
            fails = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_SETPOINT:   setpoint = value[SETPOINT_W-1:0];
                REG_PROP_GAIN:  kp = int'($signed(value));
                REG_INTEG_GAIN: ki = int'($signed(value));
                REG_DERIV_GAIN: kd = int'($signed(value));
                default: ;
            endcase
        endfunction

        // Advance the loop state by one accepted item and queue its result
        function void note_input(logic [MODE_W-1:0] mode, logic [SAMPLE_BITS-1:0] sample);
            drive_result_t res;
            longint        acc;
            longint        law;
            longint        sum_next;
            int            avg;
            int            i;
            res = '0;
            case (mode)
                MODE_CLEAR: begin
                    armed = 0;
                    error_now = 0;
                    error_prev = 0;
                    error_sum = 0;
                    res.updated = 1'b1;
                end
                MODE_ARM: begin
                    armed = 1;
                end
                MODE_STEP: begin
                    if (armed) begin
                        for (i = WINDOW - 1; i > 0; i--) window[i] = window[i-1];
                        window[0] = sample;
                        acc = 0;
                        for (i = 0; i < WINDOW; i++) acc += window[i];
                        avg = int'(acc / WINDOW);
                        error_prev = error_now;
                        sum_next = longint'(error_sum) + longint'(error_prev);
                        if (sum_next > SUM_LIMIT) sum_next = SUM_LIMIT;
                        if (sum_next < -longint'(SUM_LIMIT) - 1) sum_next = -longint'(SUM_LIMIT) - 1;
                        error_sum = int'(sum_next);
                        error_now = avg - int'(setpoint);
                        law = longint'(kp) * longint'(error_now)
                            + longint'(ki) * longint'(error_sum)
                            + longint'(kd) * (longint'(error_now) - longint'(error_prev));
                        // signed division truncates toward zero
                        law = law / (longint'(1) << FRAC_BITS);
                        if (law < 0) law = 0;
                        if (law > DRIVE_MAX) law = DRIVE_MAX;
                        res.drive = law[DRIVE_W-1:0];
                        res.updated = 1'b1;
                        res.average = avg[SAMPLE_BITS-1:0];
                        res.error_out = error_now[ERR_W-1:0];
                    end
                end
                default: ;
            endcase
            pending_results.push_back(res);
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                fails++;
            end
        endfunction

        // Match one result item against the oldest expectation
        function void check_result(logic [M_TDATA_W-1:0] tdata, logic tuser);
            drive_result_t want;
            if (pending_results.size() == 0) begin
                $error("unexpected result item: tdata %h tuser %b", tdata, tuser);
                fails++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("drive", int'(want.drive), int'(tdata[6:0]));
            compare_field("drive_updated", int'(want.updated), int'(tuser));
            compare_field("average", int'(want.average), int'(tdata[18:7]));
            compare_field("error_out", int'($signed(want.error_out)),
                          int'($signed(tdata[31:19])));
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [MODE_W-1:0]     s_tuser   = MODE_CLEAR;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    pid_scoreboard sb;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    pid_with_moving_average uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Stall the result side at random, one decision per cycle
    initial begin
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Offer one item, idling first at random; call and return at a falling edge
    task automatic send_item(logic [MODE_W-1:0] mode, logic [SAMPLE_BITS-1:0] sample);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = {{(S_TDATA_W-SAMPLE_BITS){1'b0}}, sample};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(mode, sample);
        @(negedge aclk);
    endtask

    // Hold off the sender until every expected result has come back or DRAIN_LIMIT runs out
    task automatic wait_drained();
        int waited;
        waited = 0;
        s_tvalid = 1'b0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.fails++;
        end
        @(negedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic load_gains(int unsigned sp, int p, int i, int d);
        cfg_write(REG_SETPOINT, CFG_DATA_W'(sp & 8'hFF));
        cfg_write(REG_PROP_GAIN, CFG_DATA_W'(p));
        cfg_write(REG_INTEG_GAIN, CFG_DATA_W'(i));
        cfg_write(REG_DERIV_GAIN, CFG_DATA_W'(d));
    endtask

    function automatic int signed_range(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Random setting: tame gains, both extremes, or anything at all
    task automatic apply_setting(int kind);
        case (kind)
            0: load_gains($urandom_range(0, 255), signed_range(8 << FRAC_BITS),
                          signed_range(256), signed_range(4 << FRAC_BITS));
            1: load_gains(255, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
            2: load_gains(0, 24'h800000, 24'h800000, 24'h800000);
            default: load_gains($urandom_range(0, 255), $urandom, $urandom, $urandom);
        endcase
    endtask

    // Mostly armed control steps; clear, re-arm and the unused mode now and then
    function automatic logic [MODE_W-1:0] pick_mode();
        int r;
        r = $urandom_range(99);
        if (!sb.armed && r < 60) return MODE_ARM;
        if (r < 3) return MODE_CLEAR;
        if (r < 6) return MODE_ARM;
        if (r < 8) return MODE_IGNORED;
        return MODE_STEP;
    endfunction

    // Mostly samples near the setpoint to keep the drive off its limits; some random or at either end
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int r;
        int s;
        r = $urandom_range(99);
        if (r < 20) return SAMPLE_BITS'($urandom);
        if (r < 30) return ($urandom_range(1) != 0) ? {SAMPLE_BITS{1'b1}} : '0;
        s = int'(sb.setpoint) + int'($urandom_range(0, 96)) - 48;
        if (s < 0) s = 0;
        return SAMPLE_BITS'(s);
    endfunction

    initial begin
        int phase;
        int n;
        sb = new();
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: disarmed and unused-mode items, window fill, drive limits, clear
        load_gains(255, 1 << FRAC_BITS, 16, 1 << (FRAC_BITS - 2));
        send_item(MODE_STEP, 12'hFFF);
        send_item(MODE_IGNORED, 12'hFFF);
        send_item(MODE_ARM, 12'h000);
        send_item(MODE_STEP, 12'h000);
        repeat (5) send_item(MODE_STEP, 12'hFFF);
        send_item(MODE_STEP, 12'h000);
        repeat (5) send_item(MODE_STEP, 12'd300);
        send_item(MODE_ARM, 12'hABC);
        send_item(MODE_IGNORED, 12'h555);
        send_item(MODE_CLEAR, 12'hFFF);
        send_item(MODE_STEP, 12'h123);
        send_item(MODE_ARM, 12'h000);
        send_item(MODE_STEP, 12'd255);
        send_item(MODE_STEP, 12'd256);
        send_item(MODE_STEP, 12'hAAA);
        send_item(MODE_STEP, 12'h555);

        // Random phases, each with its own setting and idle pattern
        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            apply_setting((phase % 2 == 0) ? 0 : (phase / 2) % 3 + 1);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            send_item(MODE_ARM, pick_sample());
            for (n = 0; n < PHASE_ITEMS; n++) send_item(pick_mode(), pick_sample());
        end

        // Integral windup: full-scale error lets the sum alone walk the drive up,
        // then zero samples pull the error down to zero
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        load_gains(0, 0, 1, 0);
        send_item(MODE_CLEAR, 12'h000);
        send_item(MODE_ARM, 12'h000);
        repeat (40) send_item(MODE_STEP, 12'hFFF);
        repeat (6) send_item(MODE_STEP, 12'h000);
        send_item(MODE_CLEAR, 12'h000);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/pid_ma_pkg.sv
rtl/pid_ma_front.sv
rtl/pid_ma_law.sv
rtl/pid_with_moving_average.sv
rtl/pid_ma_checker.sv
tb/tb_pid_with_moving_average.sv
